// File: hw/rtl/hnd_pkg.sv
// ----------------------------------------------------------------------------
// hnd_pkg: shared types and constants of the Hamming descriptor matcher
// Request and response structs, command codes, sizes and the popcount helper.
// ----------------------------------------------------------------------------
package hnd_pkg;

	localparam int MAX_OLD    = 512;
	localparam int DESC_BITS  = 256;
	localparam int WORD_BITS  = 64;
	localparam int DESC_WORDS = DESC_BITS / WORD_BITS;
	localparam int ADDR_W     = $clog2(MAX_OLD);
	localparam int CNT_W      = $clog2(MAX_OLD + 1);
	localparam int DIST_W     = $clog2(DESC_BITS + 1);
	localparam int PC_W       = $clog2(WORD_BITS + 1);
	localparam int POS_W      = 32;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [1:0] LAST_WORD = 2'(DESC_WORDS - 1);

	localparam logic [DIST_W-1:0] NO_MATCH_DIST = DIST_W'(DESC_BITS);

	typedef struct packed {
		logic [1:0]  command;
		logic [1:0]  word_index;
		logic [63:0] word_data;
		logic [15:0] point_x;
		logic [15:0] point_y;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] best_index;
		logic [DIST_W-1:0] best_distance;
		logic [15:0]       match_x;
		logic [15:0]       match_y;
	} rsp_t;

	// Popcount of one 64-bit word as a six-level SWAR reduction.
	function automatic logic [PC_W-1:0] popcount64(input logic [63:0] v);
		logic [63:0] x;
		x = v - ((v >> 1) & 64'h5555_5555_5555_5555);
		x = (x & 64'h3333_3333_3333_3333) + ((x >> 2) & 64'h3333_3333_3333_3333);
		x = (x + (x >> 4)) & 64'h0f0f_0f0f_0f0f_0f0f;
		x = x + (x >> 8);
		x = x + (x >> 16);
		x = x + (x >> 32);
		return x[PC_W-1:0];
	endfunction

endpackage

// File: hw/rtl/hnd_ram.sv
// ----------------------------------------------------------------------------
// hnd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hnd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/hamming_nearest_descriptor_match_unit.sv
// ----------------------------------------------------------------------------
// hamming_nearest_descriptor_match_unit: brute-force 256-bit Hamming matcher
// Stores reference descriptors with positions, answers nearest-entry queries.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req/req_valid/req_ready. A clear empties the reference
//   set, a load writes one 64-bit word of the next free entry (the entry and
//   its position are committed with the last word), a query writes one of
//   four query words. Only the last query word produces a response.
//   Clear, load and non-final query words leave req_ready high.
//   A final query word starts a walk over the stored entries: one entry per
//   cycle out of four 64-bit banks read in parallel, then a two-stage
//   popcount/compare pipeline, then one position read. The walk is bound by
//   the single read port of each bank. req_ready stays low from the last
//   query word until the result enters the output register.
//   The response sits in an output register; new requests are taken while
//   it waits. If the receiver stalls and another query finishes, the block
//   holds the new result until the output register frees up.
//   Reset empties the set and zeroes the query words. Descriptor memory is
//   not cleared; entries only count once they are written again.
// ----------------------------------------------------------------------------
module hamming_nearest_descriptor_match_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  hnd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output hnd_pkg::rsp_t rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_POS,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [hnd_pkg::CNT_W-1:0]     count_q;
	logic [hnd_pkg::CNT_W-1:0]     walk_q;
	logic [hnd_pkg::WORD_BITS-1:0] query_q [hnd_pkg::DESC_WORDS];

	logic [hnd_pkg::DIST_W-1:0] best_dist_q;
	logic [hnd_pkg::ADDR_W-1:0] best_idx_q;
	logic                       has_best_q;

	logic          rsp_valid_q;
	hnd_pkg::rsp_t rsp_q;

	// request decode
	logic accept;
	logic do_load;
	logic do_query;
	logic last_word;
	logic store_full;

	assign req_ready  = (state_q == ST_IDLE);
	assign accept     = req_valid && req_ready;
	assign store_full = (count_q >= hnd_pkg::CNT_W'(hnd_pkg::MAX_OLD));
	assign last_word  = (req.word_index == hnd_pkg::LAST_WORD);

	always_comb begin
		do_load  = 1'b0;
		do_query = 1'b0;
		unique case (req.command)
			hnd_pkg::CMD_LOAD:  do_load  = accept && !store_full;
			hnd_pkg::CMD_QUERY: do_query = accept;
			default: begin
				do_load  = 1'b0;
				do_query = 1'b0;
			end
		endcase
	end

	// Descriptor banks: one RAM per 64-bit word, all read at the same entry.
	logic                          issue;
	logic [hnd_pkg::ADDR_W-1:0]    wr_addr;
	logic [hnd_pkg::WORD_BITS-1:0] bank_rdata [hnd_pkg::DESC_WORDS];

	assign issue   = (state_q == ST_WALK) && (walk_q < count_q);
	assign wr_addr = count_q[hnd_pkg::ADDR_W-1:0];

	for (genvar b = 0; b < hnd_pkg::DESC_WORDS; b++) begin : g_bank
		hnd_ram #(
			.WIDTH (hnd_pkg::WORD_BITS),
			.DEPTH (hnd_pkg::MAX_OLD)
		) u_bank (
			.clk   (clk),
			.we    (do_load && (req.word_index == 2'(b))),
			.waddr (wr_addr),
			.wdata (req.word_data),
			.re    (issue),
			.raddr (walk_q[hnd_pkg::ADDR_W-1:0]),
			.rdata (bank_rdata[b])
		);
	end

	// Position RAM: y high, x low, written with the last load word.
	logic [hnd_pkg::POS_W-1:0] pos_rdata;

	hnd_ram #(
		.WIDTH (hnd_pkg::POS_W),
		.DEPTH (hnd_pkg::MAX_OLD)
	) u_pos (
		.clk   (clk),
		.we    (do_load && last_word),
		.waddr (wr_addr),
		.wdata ({req.point_y, req.point_x}),
		.re    (state_q == ST_POS),
		.raddr (best_idx_q),
		.rdata (pos_rdata)
	);

	// Distance pipeline: s1 has bank data, s2 has per-word popcounts.
	logic                       v_s1;
	logic [hnd_pkg::ADDR_W-1:0] idx_s1;
	logic                       v_s2;
	logic [hnd_pkg::ADDR_W-1:0] idx_s2;
	logic [hnd_pkg::PC_W-1:0]   pc_s2 [hnd_pkg::DESC_WORDS];
	logic [hnd_pkg::DIST_W-1:0] dist_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= walk_q[hnd_pkg::ADDR_W-1:0];
		idx_s2 <= idx_s1;
		for (int w = 0; w < hnd_pkg::DESC_WORDS; w++) begin
			pc_s2[w] <= hnd_pkg::popcount64(bank_rdata[w] ^ query_q[w]);
		end
	end

	always_comb begin
		dist_s2 = '0;
		for (int w = 0; w < hnd_pkg::DESC_WORDS; w++) begin
			dist_s2 = dist_s2 + hnd_pkg::DIST_W'(pc_s2[w]);
		end
	end

	// Reference count and query words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int w = 0; w < hnd_pkg::DESC_WORDS; w++) begin
				query_q[w] <= '0;
			end
		end else begin
			if (accept && req.command == hnd_pkg::CMD_CLEAR) begin
				count_q <= '0;
			end else if (do_load && last_word) begin
				count_q <= count_q + 1'b1;
			end
			if (do_query) begin
				query_q[req.word_index] <= req.word_data;
			end
		end
	end

	// Control: walk, drain, position read, output register
	logic rsp_free;
	logic rsp_load;

	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign rsp_load = (state_q == ST_FIN) && rsp_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			walk_q      <= '0;
			best_dist_q <= hnd_pkg::NO_MATCH_DIST;
			best_idx_q  <= '0;
			has_best_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// load a fresh response, or drop the current one once taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			// strictly smaller distance wins, so the lowest index keeps ties
			if (v_s2 && dist_s2 < best_dist_q) begin
				best_dist_q <= dist_s2;
				best_idx_q  <= idx_s2;
				has_best_q  <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (do_query && last_word) begin
						walk_q      <= '0;
						best_dist_q <= hnd_pkg::NO_MATCH_DIST;
						best_idx_q  <= '0;
						has_best_q  <= 1'b0;
						state_q     <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (issue) begin
						walk_q <= walk_q + 1'b1;
					end
					if (walk_q + 1'b1 >= count_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_POS;
					end
				end
				ST_POS: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (rsp_load) begin
						rsp_q.found         <= has_best_q;
						rsp_q.best_index    <= has_best_q ? best_idx_q : '0;
						rsp_q.best_distance <= best_dist_q;
						rsp_q.match_x       <= has_best_q ? pos_rdata[15:0] : '0;
						rsp_q.match_y       <= has_best_q ? pos_rdata[31:16] : '0;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hw/rtl/hnd_checker.sv
// ----------------------------------------------------------------------------
// hnd_checker: port-level checks of the Hamming descriptor matcher
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module hnd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input hnd_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input hnd_pkg::rsp_t rsp
);

	// hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// no match reports the fixed empty result
	a_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.best_distance == hnd_pkg::NO_MATCH_DIST
			&& rsp.best_index == '0 && rsp.match_x == '0 && rsp.match_y == '0)
		else $error("empty result not cleared");

	// a match lies below the descriptor width
	a_match_dist: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |-> rsp.best_distance < hnd_pkg::NO_MATCH_DIST)
		else $error("match distance out of range");

	// the final query word starts a walk, so requests stall next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.command == hnd_pkg::CMD_QUERY
			&& req.word_index == hnd_pkg::LAST_WORD |=> !req_ready)
		else $error("request taken during walk");

endmodule

bind hamming_nearest_descriptor_match_unit hnd_checker u_hnd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// File: tb/hnd_match_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// hnd_match_scoreboard_pkg: expected-match tracking for the descriptor matcher
// Mirrors the reference store and query words, predicts the nearest entry for
// every final query word, and compares the block's responses in order.
// ----------------------------------------------------------------------------
package hnd_match_scoreboard_pkg;
	import hnd_pkg::*;

	class match_scoreboard;
		logic [63:0]         ref_words [MAX_OLD*DESC_WORDS];
		logic [31:0]         ref_pos [MAX_OLD];
		bit [DESC_WORDS-1:0] word_seen [MAX_OLD];
		int unsigned         ref_count;
		logic [63:0]         query_words [DESC_WORDS];
		rsp_t                expected_matches [$];
		int unsigned         mismatches;

		function new();
			foreach (ref_words[i]) ref_words[i] = '0;
			foreach (ref_pos[i]) ref_pos[i] = '0;
			foreach (word_seen[i]) word_seen[i] = '0;
			foreach (query_words[i]) query_words[i] = '0;
			ref_count  = 0;
			mismatches = 0;
		endfunction

		// Walk the stored entries; the first one at the strictly smallest
		// distance below a full mismatch wins.
		function rsp_t nearest_entry();
			rsp_t        m;
			int unsigned best_d;
			int unsigned best_e;
			int unsigned d;
			bit          hit;
			best_d = DESC_BITS;
			best_e = 0;
			hit    = 1'b0;
			for (int unsigned e = 0; e < ref_count; e++) begin
				d = 0;
				for (int w = 0; w < DESC_WORDS; w++)
					d += $countones(ref_words[e*DESC_WORDS + w] ^ query_words[w]);
				if (d < best_d) begin
					best_d = d;
					best_e = e;
					hit    = 1'b1;
				end
			end
			m.found         = hit;
			m.best_index    = hit ? ADDR_W'(best_e) : '0;
			m.best_distance = DIST_W'(best_d);
			m.match_x       = hit ? ref_pos[best_e][15:0] : 16'h0000;
			m.match_y       = hit ? ref_pos[best_e][31:16] : 16'h0000;
			return m;
		endfunction

		function void note_request(req_t r);
			case (r.command)
				CMD_CLEAR: begin
					ref_count = 0;
				end
				CMD_LOAD: begin
					// drop loads into a full store
					if (ref_count < MAX_OLD) begin
						ref_words[ref_count*DESC_WORDS + r.word_index] = r.word_data;
						word_seen[ref_count][r.word_index] = 1'b1;
						if (r.word_index == LAST_WORD) begin
							ref_pos[ref_count] = {r.point_y, r.point_x};
							ref_count++;
						end
					end
				end
				CMD_QUERY: begin
					query_words[r.word_index] = r.word_data;
					if (r.word_index == LAST_WORD)
						expected_matches = {expected_matches, nearest_entry()};
				end
				default: begin
				end
			endcase
		endfunction

		task flag_mismatch(input string msg);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_result(input rsp_t got);
			rsp_t want;
			if (expected_matches.size() == 0) begin
				flag_mismatch($sformatf("response with nothing pending: found=%0d idx=%0d dist=%0d",
					got.found, got.best_index, got.best_distance));
				return;
			end
			want = expected_matches.pop_front();
			if (got.found !== want.found)
				flag_mismatch($sformatf("found exp %0d got %0d", want.found, got.found));
			if (got.best_index !== want.best_index)
				flag_mismatch($sformatf("best_index exp %0d got %0d",
					want.best_index, got.best_index));
			if (got.best_distance !== want.best_distance)
				flag_mismatch($sformatf("best_distance exp %0d got %0d",
					want.best_distance, got.best_distance));
			if (got.match_x !== want.match_x)
				flag_mismatch($sformatf("match_x exp %h got %h", want.match_x, got.match_x));
			if (got.match_y !== want.match_y)
				flag_mismatch($sformatf("match_y exp %h got %h", want.match_y, got.match_y));
		endtask

		function int unsigned pending();
			return expected_matches.size();
		endfunction

		function int unsigned stored_count();
			return ref_count;
		endfunction

		function bit word_written(int unsigned e, int w);
			return word_seen[e][w];
		endfunction

		function logic [63:0] stored_word(int unsigned e, int w);
			return ref_words[e*DESC_WORDS + w];
		endfunction
	endclass

endpackage

// File: tb/tb_hamming_nearest_descriptor_match_unit.sv
// ----------------------------------------------------------------------------
// tb_hamming_nearest_descriptor_match_unit: testbench of the descriptor matcher
// Drives clear, load and query requests, predicts every nearest-entry
// response and checks it in order, under several sender and receiver idling
// patterns, a long receiver hold-off and a completely filled store.
// ----------------------------------------------------------------------------
module tb_hamming_nearest_descriptor_match_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import hnd_pkg::*;
	import hnd_match_scoreboard_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 4;
	localparam int RANDOM_ITEMS   = 1450;
	localparam int PRESSURE_HOLD  = 1500;
	localparam int DRAIN_CYCLES   = MAX_OLD + 100;
	// longest quiet stretch: the hold-off plus a full walk, with margin
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int CLEAR_LEVEL    = 24;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_left;
	int unsigned items_sent;
	int unsigned quiet_cycles;

	match_scoreboard sb = new();

	hamming_nearest_descriptor_match_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// Receiver: hold off for the requested stretch first, otherwise stall at
	// the phase's rate. ready changes only at the falling edge.
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Check every accepted response against the oldest prediction.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && rsp_ready)
				sb.check_result(rsp);
		end
	end

	// Watchdog: count cycles in which neither channel moves anything.
	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
		$display("tb_hamming_nearest_descriptor_match_unit: FAIL");
		$finish;
	end

	// Offer one request after a random idle gap, hold it until accepted, then
	// note it with the predictor. Returns right after the accepting edge.
	task automatic push_request(input req_t r);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
		if (r.command != CMD_UNUSED)
			items_sent++;
	endtask

	task automatic send_word(input logic [1:0] cmd, input logic [1:0] idx,
			input logic [63:0] data, input logic [15:0] x, input logic [15:0] y);
		req_t r;
		r.command    = cmd;
		r.word_index = idx;
		r.word_data  = data;
		r.point_x    = x;
		r.point_y    = y;
		push_request(r);
	endtask

	// A last word may commit an entry only when its other words were written
	// at some point since reset; otherwise redirect it to a missing word.
	function automatic logic [1:0] safe_load_index(input logic [1:0] idx);
		if (idx == LAST_WORD && sb.stored_count() < MAX_OLD) begin
			for (int w = 0; w < DESC_WORDS - 1; w++)
				if (!sb.word_written(sb.stored_count(), w))
					return 2'(w);
		end
		return idx;
	endfunction

	task automatic send_load(input logic [1:0] idx, input logic [63:0] data,
			input logic [15:0] x, input logic [15:0] y);
		send_word(CMD_LOAD, safe_load_index(idx), data, x, y);
	endtask

	// style 0: in order; 1: first three words shuffled; 2: rewrite a random
	// subset and keep stale words for the rest. Position rides on the last word.
	task automatic send_entry(input logic [DESC_BITS-1:0] d, input logic [15:0] x,
			input logic [15:0] y, input int style);
		int order [3];
		int j;
		int t;
		order = '{0, 1, 2};
		if (style == 1) begin
			for (int i = 2; i > 0; i--) begin
				j        = $urandom_range(i);
				t        = order[i];
				order[i] = order[j];
				order[j] = t;
			end
		end
		for (int i = 0; i < 3; i++)
			if (style != 2 || $urandom_range(1))
				send_load(2'(order[i]), d[order[i]*WORD_BITS +: WORD_BITS],
					16'($urandom), 16'($urandom));
		send_load(LAST_WORD, d[DESC_BITS-1 -: WORD_BITS], x, y);
	endtask

	task automatic send_query(input logic [DESC_BITS-1:0] q, input bit shuffle);
		int order [4];
		int j;
		int t;
		order = '{0, 1, 2, 3};
		if (shuffle) begin
			for (int i = 3; i > 0; i--) begin
				j        = $urandom_range(i);
				t        = order[i];
				order[i] = order[j];
				order[j] = t;
			end
		end
		for (int i = 0; i < 4; i++)
			send_word(CMD_QUERY, 2'(order[i]), q[order[i]*WORD_BITS +: WORD_BITS],
				16'($urandom), 16'($urandom));
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [DESC_BITS-1:0] rand_desc();
		logic [DESC_BITS-1:0] d;
		int unsigned          sel;
		sel = $urandom_range(99);
		for (int w = 0; w < DESC_WORDS; w++)
			d[w*WORD_BITS +: WORD_BITS] = (sel < 90) ? rand64() : rand64() & rand64() & rand64();
		if (sel >= 70 && sel < 80)
			d = '0;
		else if (sel >= 80 && sel < 90)
			d = '1;
		return d;
	endfunction

	function automatic logic [DESC_BITS-1:0] stored_desc(input int unsigned e);
		logic [DESC_BITS-1:0] d;
		for (int w = 0; w < DESC_WORDS; w++)
			d[w*WORD_BITS +: WORD_BITS] = sb.stored_word(e, w);
		return d;
	endfunction

	// Half near copies of stored entries (when any are stored) so that close and tied distances
	// occur; complements push toward a full mismatch.
	function automatic logic [DESC_BITS-1:0] pick_query();
		logic [DESC_BITS-1:0] q;
		int unsigned          sel;
		sel = $urandom_range(99);
		if (sb.stored_count() == 0 || sel >= 60)
			return rand_desc();
		q = stored_desc($urandom_range(sb.stored_count() - 1));
		if (sel < 50) begin
			repeat ($urandom_range(8))
				q[$urandom_range(DESC_BITS - 1)] ^= 1'b1;
		end else begin
			q = ~q;
		end
		return q;
	endfunction

	function automatic logic [DESC_BITS-1:0] pick_entry_desc();
		if (sb.stored_count() != 0 && $urandom_range(99) < 15)
			return stored_desc($urandom_range(sb.stored_count() - 1));
		return rand_desc();
	endfunction

	task automatic random_entry();
		int style;
		style = $urandom_range(2);
		// stale rewrites only make sense on an entry written before
		if (style == 2 && (sb.stored_count() >= MAX_OLD ||
				!(sb.word_written(sb.stored_count(), 0) &&
				  sb.word_written(sb.stored_count(), 1) &&
				  sb.word_written(sb.stored_count(), 2))))
			style = 0;
		send_entry(pick_entry_desc(), 16'($urandom), 16'($urandom), style);
	endtask

	task automatic random_phase(input int unsigned n_items);
		int unsigned target;
		int unsigned sel;
		target = items_sent + n_items;
		while (items_sent < target) begin
			sel = $urandom_range(99);
			if (sb.stored_count() >= CLEAR_LEVEL && sel < 30)
				send_word(CMD_CLEAR, 2'($urandom), rand64(), 16'($urandom), 16'($urandom));
			else if (sel < 45)
				random_entry();
			else if (sel < 80)
				send_query(pick_query(), $urandom_range(3) == 0);
			else if (sel < 85)
				send_word(CMD_CLEAR, 2'($urandom), rand64(), 16'($urandom), 16'($urandom));
			else if (sel < 90)
				send_word(CMD_UNUSED, 2'($urandom), rand64(), 16'($urandom), 16'($urandom));
			else if (sel < 95)
				send_load(2'($urandom), rand64(), 16'($urandom), 16'($urandom));
			else
				send_word(CMD_QUERY, 2'($urandom), rand64(), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 0;
		items_sent     = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: query an empty set, exact hits at both data extremes,
		// a full mismatch on every entry, a tie, and an unknown command.
		send_word(CMD_QUERY, LAST_WORD, 64'h0, 16'h0000, 16'h0000);
		send_entry('0, 16'hFFFF, 16'h0000, 0);
		send_entry('1, 16'h0000, 16'hFFFF, 0);
		send_query('1, 1'b0);
		send_word(CMD_CLEAR, 2'd0, 64'h0, 16'h0000, 16'h0000);
		send_entry('0, 16'h1234, 16'hABCD, 0);
		send_entry('0, 16'hFFFF, 16'hFFFF, 0);
		// query words are still all ones: every entry is at distance 256
		send_word(CMD_QUERY, LAST_WORD, '1, 16'hFFFF, 16'hFFFF);
		send_query('0, 1'b0);
		send_word(CMD_UNUSED, LAST_WORD, '1, 16'hFFFF, 16'hFFFF);

		// Pressure: hold the receiver off while queries keep coming, so the
		// output register and the held result fill and requests back up.
		send_word(CMD_CLEAR, 2'd0, 64'h0, 16'h0000, 16'h0000);
		repeat (3) random_entry();
		hold_left = PRESSURE_HOLD;
		repeat (8) send_query(pick_query(), 1'b0);

		// Fill the store completely, then check that further loads drop and
		// the last entry is reachable.
		send_word(CMD_CLEAR, 2'd0, 64'h0, 16'h0000, 16'h0000);
		for (int e = 0; e < MAX_OLD; e++)
			send_entry({rand64(), rand64(), rand64(), rand64()},
				16'($urandom), 16'($urandom), 0);
		send_load(2'd0, rand64(), 16'($urandom), 16'($urandom));
		send_load(LAST_WORD, rand64(), 16'($urandom), 16'($urandom));
		send_query(stored_desc(MAX_OLD - 1), 1'b0);
		send_query(stored_desc(0), 1'b1);
		send_word(CMD_CLEAR, 2'd0, 64'h0, 16'h0000, 16'h0000);

		// Random traffic under each idling pattern.
		random_phase(RANDOM_ITEMS / 4);
		send_idle_pct = 70;
		random_phase(RANDOM_ITEMS / 4);
		send_idle_pct  = 0;
		recv_stall_pct = 70;
		random_phase(RANDOM_ITEMS / 4);
		send_idle_pct  = 17;
		recv_stall_pct = 17;
		random_phase(RANDOM_ITEMS / 4);

		// Drop valid, drain the pending responses, then watch for strays.
		@(negedge clk);
		req_valid     <= 1'b0;
		recv_stall_pct = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb_hamming_nearest_descriptor_match_unit: PASS");
		end else begin
			$display("tb_hamming_nearest_descriptor_match_unit: FAIL");
		end
		$finish;
	end

endmodule
